// ----- design/hri_pkg.sv -----
package hri_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned TOL_W = 31;
	localparam int unsigned LIM_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 2'd1;

	localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;
	localparam logic [LIM_W-1:0] LIM_RESET = 16'd50;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	localparam logic [1:0] STATUS_PROBING = 2'd0;
	localparam logic [1:0] STATUS_CONVERGED = 2'd1;
	localparam logic [1:0] STATUS_ZERO_DERIV = 2'd2;
	localparam logic [1:0] STATUS_LIMIT = 2'd3;

	localparam logic [31:0] CAP_POS = 32'h7FFF_FFFF;
	localparam logic [31:0] CAP_NEG = 32'h8000_0000;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_MUL_P  = 10'b00_0000_0010,
		ST_MUL_Q  = 10'b00_0000_0100,
		ST_MUL_N  = 10'b00_0000_1000,
		ST_TEST   = 10'b00_0001_0000,
		ST_DIV_GO = 10'b00_0010_0000,
		ST_DIV    = 10'b00_0100_0000,
		ST_UPD    = 10'b00_1000_0000,
		ST_FIN    = 10'b01_0000_0000,
		ST_SPARE  = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

endpackage

// ----- design/halley_root_iteration_core.sv -----
// Start items, and evaluations that arrive while no run is active, go straight to the
// result stage. An evaluation that runs the full update takes three multiplier passes,
// a 32-step radix-2 divider (one quotient bit per cycle) and the update. Converged
// evaluations finish at the tolerance test, zero-derivative ones before the divider.
// One item is in work at a time; s_tready is low until the result is handed to the output.
// arst_n clears the root, count and run flag and loads tolerance 66 and limit 50.
module halley_root_iteration_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hri_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hri_pkg::TOL_W-1:0]          cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// start_x [31:0], f_value [63:32], d1_value [95:64], d2_value [127:96]
	input  logic [127:0]                       s_tdata,
	// req_type [0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// probe_x [31:0], iterations [47:32]
	output logic [47:0]                        m_tdata,
	// done_res
	output logic                               m_tlast,
	// status [1:0]
	output logic [1:0]                         m_tuser
);

	hri_pkg::state_t state_q;

	logic [hri_pkg::TOL_W-1:0] tol_q;
	logic [hri_pkg::LIM_W-1:0] lim_q;
	logic signed [31:0]        root_q;
	logic [15:0]               count_q;
	logic                      active_q;

	logic signed [31:0] f_q, d1_q, d2_q;
	logic [63:0]        dpos_q;
	logic [63:0]        dmag_q;
	logic               dneg_q;
	logic [63:0]        nmag_q;
	logic               neg_q;

	logic signed [31:0] res_x_q;
	logic               res_done_q;
	logic [1:0]         res_status_q;

	logic               m_tvalid_q;
	logic [31:0]        m_x_q;
	logic [15:0]        m_iter_q;
	logic               m_done_q;
	logic [1:0]         m_status_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] product_q;

	logic               div_start;
	hri_pkg::div_stat_t div_stat;
	logic [31:0]        quo_q;

	logic [31:0] f_mag;
	logic [63:0] q_mag;
	logic [63:0] nf_mag;
	logic [31:0] cap;
	logic [31:0] qmag;
	logic [33:0] step;
	logic [33:0] next_full;
	logic [31:0] next_root;
	logic        accept;

	assign s_tready = state_q == hri_pkg::ST_IDLE;
	assign accept = s_tvalid && s_tready;

	always_comb begin
		case (state_q)
			hri_pkg::ST_MUL_P: begin
				mul_a = d1_q;
				mul_b = d1_q;
			end
			hri_pkg::ST_MUL_Q: begin
				mul_a = f_q;
				mul_b = d2_q;
			end
			default: begin
				mul_a = f_q;
				mul_b = d1_q;
			end
		endcase
	end

	hri_mul u_mul (
		.clk       (clk),
		.a         (mul_a),
		.b         (mul_b),
		.product_q (product_q)
	);

	assign div_start = state_q == hri_pkg::ST_DIV_GO;

	hri_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.nmag   (nmag_q),
		.dmag   (dmag_q),
		.stat   (div_stat),
		.quo_q  (quo_q)
	);

	assign f_mag = f_q[31] ? 32'(-f_q) : 32'(f_q);
	assign q_mag = product_q[63] ? 64'(-product_q) : 64'(product_q);
	assign nf_mag = q_mag;

	assign cap = neg_q ? hri_pkg::CAP_NEG : hri_pkg::CAP_POS;
	assign qmag = (div_stat.ovf || quo_q > cap) ? cap : quo_q;
	assign step = neg_q ? -{2'b00, qmag} : {2'b00, qmag};
	assign next_full = {{2{root_q[31]}}, root_q} - step;

	always_comb begin
		if (next_full[33:31] == 3'b000 || next_full[33:31] == 3'b111) begin
			next_root = next_full[31:0];
		end else if (next_full[33]) begin
			next_root = hri_pkg::CAP_NEG;
		end else begin
			next_root = hri_pkg::CAP_POS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hri_pkg::ST_IDLE;
			tol_q <= hri_pkg::TOL_RESET;
			lim_q <= hri_pkg::LIM_RESET;
			root_q <= '0;
			count_q <= '0;
			active_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					hri_pkg::CFG_TOLERANCE: tol_q <= cfg_data;
					hri_pkg::CFG_ITER_LIMIT: lim_q <= cfg_data[hri_pkg::LIM_W-1:0];
					default: ;
				endcase
			end

			// In the final state the handover below decides the valid flag.
			if (m_tvalid_q && m_tready && state_q != hri_pkg::ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				hri_pkg::ST_IDLE: begin
					if (accept) begin
						if (s_tuser == hri_pkg::REQ_START) begin
							root_q <= s_tdata[31:0];
							count_q <= '0;
							active_q <= lim_q != '0;
							state_q <= hri_pkg::ST_FIN;
						end else if (!active_q) begin
							state_q <= hri_pkg::ST_FIN;
						end else begin
							if (count_q != 16'hFFFF) begin
								count_q <= count_q + 16'd1;
							end
							state_q <= hri_pkg::ST_MUL_P;
						end
					end
				end
				hri_pkg::ST_MUL_P: begin
					if (f_mag <= {1'b0, tol_q}) begin
						active_q <= 1'b0;
						state_q <= hri_pkg::ST_FIN;
					end else begin
						state_q <= hri_pkg::ST_MUL_Q;
					end
				end
				hri_pkg::ST_MUL_Q: state_q <= hri_pkg::ST_MUL_N;
				hri_pkg::ST_MUL_N: state_q <= hri_pkg::ST_TEST;
				hri_pkg::ST_TEST: begin
					if (dmag_q <= {17'd0, tol_q, 16'd0}) begin
						active_q <= 1'b0;
						state_q <= hri_pkg::ST_FIN;
					end else begin
						state_q <= hri_pkg::ST_DIV_GO;
					end
				end
				hri_pkg::ST_DIV_GO: state_q <= hri_pkg::ST_DIV;
				hri_pkg::ST_DIV: begin
					if (div_stat.done) begin
						state_q <= hri_pkg::ST_UPD;
					end
				end
				hri_pkg::ST_UPD: begin
					root_q <= next_root;
					if (count_q >= lim_q) begin
						active_q <= 1'b0;
					end
					state_q <= hri_pkg::ST_FIN;
				end
				hri_pkg::ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q <= hri_pkg::ST_IDLE;
					end
				end
				default: state_q <= hri_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers; the sequencer above decides when they matter.
	always_ff @(posedge clk) begin
		case (state_q)
			hri_pkg::ST_IDLE: begin
				if (accept) begin
					f_q <= s_tdata[63:32];
					d1_q <= s_tdata[95:64];
					d2_q <= s_tdata[127:96];
					if (s_tuser == hri_pkg::REQ_START) begin
						res_x_q <= s_tdata[31:0];
						res_done_q <= lim_q == '0;
						res_status_q <= (lim_q == '0) ? hri_pkg::STATUS_LIMIT
							: hri_pkg::STATUS_PROBING;
					end else begin
						res_x_q <= root_q;
						res_done_q <= 1'b1;
						res_status_q <= hri_pkg::STATUS_PROBING;
					end
				end
			end
			hri_pkg::ST_MUL_P: begin
				res_x_q <= root_q;
				res_done_q <= 1'b1;
				res_status_q <= hri_pkg::STATUS_CONVERGED;
			end
			hri_pkg::ST_MUL_Q: begin
				// d1 squared is never negative and at most 2^62, so doubling fits.
				dpos_q <= {product_q[62:0], 1'b0};
			end
			hri_pkg::ST_MUL_N: begin
				if (product_q[63] || product_q == '0) begin
					dneg_q <= 1'b0;
					dmag_q <= dpos_q + q_mag;
				end else if (64'(product_q) > dpos_q) begin
					dneg_q <= 1'b1;
					dmag_q <= 64'(product_q) - dpos_q;
				end else begin
					dneg_q <= 1'b0;
					dmag_q <= dpos_q - 64'(product_q);
				end
			end
			hri_pkg::ST_TEST: begin
				nmag_q <= {nf_mag[62:0], 1'b0};
				neg_q <= product_q[63] != dneg_q;
				res_x_q <= root_q;
				res_done_q <= 1'b1;
				res_status_q <= hri_pkg::STATUS_ZERO_DERIV;
			end
			hri_pkg::ST_UPD: begin
				res_x_q <= next_root;
				res_done_q <= count_q >= lim_q;
				res_status_q <= (count_q >= lim_q) ? hri_pkg::STATUS_LIMIT
					: hri_pkg::STATUS_PROBING;
			end
			hri_pkg::ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					m_x_q <= res_x_q;
					m_iter_q <= count_q;
					m_done_q <= res_done_q;
					m_status_q <= res_status_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {m_iter_q, m_x_q};
	assign m_tlast = m_done_q;
	assign m_tuser = m_status_q;

endmodule

// ----- design/hri_mul.sv -----
module hri_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] product_q
);

	always_ff @(posedge clk) begin
		product_q <= a * b;
	end

endmodule

// ----- design/hri_div.sv -----
module hri_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [63:0]            nmag,
	input  logic [63:0]            dmag,
	output hri_pkg::div_stat_t     stat,
	output logic [31:0]            quo_q
);

	logic        busy_q;
	logic        done_q;
	logic        ovf_q;
	logic [4:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] d_q;
	logic [31:0] num_q;
	logic [64:0] trial;
	logic        ge;
	logic [64:0] diff;

	assign trial = {rem_q, num_q[31]};
	assign ge = trial >= {1'b0, d_q};
	assign diff = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (start) begin
				// A quotient of 2^32 or more always saturates, so the
				// long division only needs the low 32 quotient bits.
				ovf_q <= {16'd0, nmag} >= {dmag, 16'd0};
				if ({16'd0, nmag} >= {dmag, 16'd0}) begin
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
					busy_q <= 1'b1;
					cnt_q <= 5'd31;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				done_q <= cnt_q == 5'd0;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= dmag;
			rem_q <= {16'd0, nmag[63:16]};
			num_q <= {nmag[15:0], 16'd0};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : trial[63:0];
			num_q <= {num_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign stat.done = done_q;
	assign stat.ovf = ovf_q;

endmodule

// ----- design/hri_chk.sv -----
module hri_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [47:0]  m_tdata,
	input logic         m_tlast,
	input logic [1:0]   m_tuser
);

	// Only one item is in work, so the input closes right after an accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in work");

	// A nonzero status always ends the run.
	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != hri_pkg::STATUS_PROBING |-> m_tlast)
		else $error("terminal status without done");

	// A held result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind halley_root_iteration_core hri_chk u_hri_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ----- tb/tb_halley_root_iteration_core.sv -----
module tb_halley_root_iteration_core;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	// Indexes past the two registers; writes there must be ignored.
	localparam logic [hri_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
	localparam logic [hri_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

	typedef struct {
		logic               req;
		logic signed [31:0] x0;
		logic signed [31:0] fv;
		logic signed [31:0] d1;
		logic signed [31:0] d2;
		bit                 drain;
	} halley_req_t;

	typedef struct {
		logic [31:0] probe;
		logic        done;
		logic [1:0]  status;
		logic [15:0] iters;
	} halley_res_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [hri_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hri_pkg::TOL_W-1:0]     cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [127:0]                  s_tdata = '0;
	logic                          s_tuser = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [47:0]                   m_tdata;
	logic                          m_tlast;
	logic [1:0]                    m_tuser;

	halley_root_iteration_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	// Predictor state and its copy of the registers.
	logic [hri_pkg::TOL_W-1:0] pred_tol = hri_pkg::TOL_RESET;
	logic [hri_pkg::LIM_W-1:0] pred_limit = hri_pkg::LIM_RESET;
	logic signed [31:0]        pred_root = '0;
	logic [15:0]               pred_count = '0;
	logic                      pred_active = 1'b0;

	halley_req_t stim_q[$];
	halley_res_t probe_exp_q[$];
	halley_req_t cur_item;
	logic        took = 1'b0;
	int          burst_left = 1;
	int          gap_left = 0;
	int          rx_wait = 0;
	int          err_cnt = 0;
	int          res_cnt = 0;
	int unsigned cycle_cnt = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] abs_q(logic signed [63:0] v);
		return v[63] ? -v : v;
	endfunction

	function automatic halley_res_t pack_probe(logic done, logic [1:0] status);
		halley_res_t r;
		r.probe = pred_root;
		r.done = done;
		r.status = status;
		r.iters = pred_count;
		return r;
	endfunction

	// One Halley step on the predictor state; every item gives one result.
	function automatic halley_res_t halley_step(halley_req_t it);
		logic signed [63:0] fw, p, q, nf, rootw, step, nxt;
		logic [63:0]        dpos, dmag, nmag, cap;
		logic [79:0]        quo;
		logic               dneg, neg;
		if (it.req == hri_pkg::REQ_START) begin
			pred_root = it.x0;
			pred_count = '0;
			if (pred_limit == '0) begin
				pred_active = 1'b0;
				return pack_probe(1'b1, hri_pkg::STATUS_LIMIT);
			end
			pred_active = 1'b1;
			return pack_probe(1'b0, hri_pkg::STATUS_PROBING);
		end
		if (!pred_active)
			return pack_probe(1'b1, hri_pkg::STATUS_PROBING);
		if (pred_count != 16'hFFFF)
			pred_count = pred_count + 16'd1;
		fw = 64'(it.fv);
		if (abs_q(fw) <= pred_tol) begin
			pred_active = 1'b0;
			return pack_probe(1'b1, hri_pkg::STATUS_CONVERGED);
		end
		// Denominator 2 f'^2 - f f'' at Q.32 scale as sign and magnitude.
		p = 64'(it.d1) * 64'(it.d1);
		q = 64'(it.fv) * 64'(it.d2);
		dpos = p << 1;
		if (q <= 0) begin
			dneg = 1'b0;
			dmag = dpos + abs_q(q);
		end else if ($unsigned(q) > dpos) begin
			dneg = 1'b1;
			dmag = $unsigned(q) - dpos;
		end else begin
			dneg = 1'b0;
			dmag = dpos - $unsigned(q);
		end
		if (dmag <= {pred_tol, 16'd0}) begin
			pred_active = 1'b0;
			return pack_probe(1'b1, hri_pkg::STATUS_ZERO_DERIV);
		end
		nf = 64'(it.fv) * 64'(it.d1);
		nmag = abs_q(nf) << 1;
		neg = nf[63] ^ dneg;
		cap = neg ? {32'd0, hri_pkg::CAP_NEG} : {32'd0, hri_pkg::CAP_POS};
		quo = {nmag, 16'd0} / {16'd0, dmag};
		if (quo > {16'd0, cap})
			quo = {16'd0, cap};
		step = neg ? -$signed(quo[63:0]) : $signed(quo[63:0]);
		rootw = 64'(pred_root);
		nxt = rootw - step;
		if (nxt > 64'sd2147483647)
			nxt = 64'sd2147483647;
		else if (nxt < -64'sd2147483648)
			nxt = -64'sd2147483648;
		pred_root = nxt[31:0];
		if (pred_count >= pred_limit) begin
			pred_active = 1'b0;
			return pack_probe(1'b1, hri_pkg::STATUS_LIMIT);
		end
		return pack_probe(1'b0, hri_pkg::STATUS_PROBING);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_cnt++;
		$display("result %0d: %s is %h, predicted %h", res_cnt, what, got, want);
	endtask

	// Sender: bursts of items separated by random gaps.
	always @(negedge clk) begin
		halley_req_t nxt_item;
		int          r;
		if (arst_n && (!s_tvalid || took)) begin
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (stim_q.size() != 0 &&
					!(stim_q[0].drain && probe_exp_q.size() != 0)) begin
				nxt_item = stim_q.pop_front();
				cur_item <= nxt_item;
				s_tdata <= {nxt_item.d2, nxt_item.d1, nxt_item.fv, nxt_item.x0};
				s_tuser <= nxt_item.req;
				s_tvalid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) :
						$urandom_range(1, 12);
					r = $urandom_range(0, 19);
					if (r < 5)
						gap_left = 0;
					else if (r < 18)
						gap_left = $urandom_range(1, 10);
					else
						gap_left = $urandom_range(20, 60);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: rotates through four stall patterns: always ready, random, random waits and mostly ready.
	always @(negedge clk) begin
		logic rdy;
		case ((cycle_cnt / 300) % 4)
			0: rdy = 1'b1;
			1: rdy = 1'($urandom_range(0, 1));
			2: begin
				if (rx_wait != 0) begin
					rx_wait--;
					rdy = 1'b0;
				end else begin
					rdy = 1'b1;
					if ($urandom_range(0, 3) == 0)
						rx_wait = $urandom_range(1, 40);
				end
			end
			default: rdy = ($urandom_range(0, 9) != 0);
		endcase
		m_tready <= rdy;
	end

	// Monitor: checks results, predicts accepted items, and guards the run length.
	always @(posedge clk) begin
		halley_res_t want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("status: fail");
			$finish;
		end
		took <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (probe_exp_q.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata[31:0], '0);
				end else begin
					want = probe_exp_q.pop_front();
					if (m_tdata[31:0] !== want.probe)
						report_mismatch("probe_x", m_tdata[31:0], want.probe);
					if (m_tlast !== want.done)
						report_mismatch("done_res", 32'(m_tlast), 32'(want.done));
					if (m_tuser !== want.status)
						report_mismatch("status", 32'(m_tuser), 32'(want.status));
					if (m_tdata[47:32] !== want.iters)
						report_mismatch("iterations", 32'(m_tdata[47:32]),
							32'(want.iters));
				end
				res_cnt++;
			end
			if (s_tvalid && s_tready)
				probe_exp_q.push_back(halley_step(cur_item));
		end
	end

	task automatic push_item(input logic req, input logic [31:0] x0, input logic [31:0] fv,
			input logic [31:0] d1, input logic [31:0] d2, input bit drain);
		halley_req_t it;
		it.req = req;
		it.x0 = x0;
		it.fv = fv;
		it.d1 = d1;
		it.d2 = d2;
		it.drain = drain;
		stim_q.push_back(it);
	endtask

	task automatic write_reg(input logic [hri_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[hri_pkg::TOL_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == hri_pkg::CFG_TOLERANCE)
			pred_tol = val[hri_pkg::TOL_W-1:0];
		else if (idx == hri_pkg::CFG_ITER_LIMIT)
			pred_limit = val[hri_pkg::LIM_W-1:0];
	endtask

	task automatic settle();
		while (stim_q.size() != 0 || s_tvalid || probe_exp_q.size() != 0)
			@(posedge clk);
	endtask

	// Values of a plausible magnitude, roughly +-16.0.
	function automatic logic [31:0] rand_mid();
		return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3, 4, 5: return rand_mid();
			default: return $urandom;
		endcase
	endfunction

	// A start followed by evaluations; a terminating evaluation usually ends it.
	task automatic add_sequence(input int term_pct, inout int added);
		int                 n_eval, pick;
		logic [31:0]        mag;
		logic signed [31:0] r;
		push_item(hri_pkg::REQ_START, rand_word(), $urandom, $urandom, $urandom,
			$urandom_range(0, 49) == 0);
		added++;
		n_eval = (pred_limit == '0) ? 1 :
			$urandom_range(1, (pred_limit < 30) ? pred_limit + 2 : 32);
		for (int k = 0; k < n_eval; k++) begin
			pick = $urandom_range(0, 99);
			added++;
			if (pick < term_pct / 2) begin
				mag = $urandom_range(0, (pred_tol > 4096) ? 4096 : pred_tol);
				r = mag;
				if ($urandom_range(0, 1))
					r = -r;
				push_item(hri_pkg::REQ_EVAL, $urandom, r, rand_word(), rand_word(), 1'b0);
				if ($urandom_range(0, 3) != 0)
					break;
			end else if (pick < term_pct) begin
				r = rand_mid();
				// Either a flat derivative or f f'' cancelling 2 f'^2 exactly.
				if ($urandom_range(0, 1))
					push_item(hri_pkg::REQ_EVAL, $urandom, rand_word(), '0, '0, 1'b0);
				else
					push_item(hri_pkg::REQ_EVAL, $urandom, r, r, r <<< 1, 1'b0);
				if ($urandom_range(0, 3) != 0)
					break;
			end else if (pick < 85) begin
				push_item(hri_pkg::REQ_EVAL, $urandom, rand_mid(), rand_mid(), rand_mid(),
					1'b0);
			end else begin
				push_item(hri_pkg::REQ_EVAL, $urandom, rand_word(), rand_word(), rand_word(),
					1'b0);
			end
		end
	endtask

	task automatic run_random(input int n, input int term_pct);
		int added;
		added = 0;
		while (added < n) begin
			if ($urandom_range(0, 9) == 0) begin
				push_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
					1'b0);
				added++;
			end else begin
				add_sequence(term_pct, added);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: tolerance 66, limit 50.
		push_item(hri_pkg::REQ_EVAL, $urandom, 5, 6, 7, 1'b0);
		run_random(150, 30);
		push_item(hri_pkg::REQ_START, 32'h7FFF_FFFF, $urandom, $urandom, $urandom, 1'b0);
		push_item(hri_pkg::REQ_EVAL, $urandom, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		push_item(hri_pkg::REQ_START, 32'h8000_0000, $urandom, $urandom, $urandom, 1'b0);
		push_item(hri_pkg::REQ_EVAL, $urandom, 66, 1, 1, 1'b0);
		// Denominator exactly on the bound, then just above it with a zero step.
		push_item(hri_pkg::REQ_START, 32'h0001_0000, $urandom, $urandom, $urandom, 1'b0);
		push_item(hri_pkg::REQ_EVAL, $urandom, -1024, 0, 4224, 1'b0);
		push_item(hri_pkg::REQ_START, 32'h0001_0000, $urandom, $urandom, $urandom, 1'b0);
		push_item(hri_pkg::REQ_EVAL, $urandom, -1024, 0, 4225, 1'b0);
		// The quotient clips and the root clips at both ends.
		push_item(hri_pkg::REQ_START, 32'h8000_0000, $urandom, $urandom, $urandom, 1'b0);
		push_item(hri_pkg::REQ_EVAL, $urandom, 32'h7FFF_FFFF, 32'h0001_0000, 3, 1'b0);
		push_item(hri_pkg::REQ_START, 32'h7FFF_FFFF, $urandom, $urandom, $urandom, 1'b0);
		push_item(hri_pkg::REQ_EVAL, $urandom, 32'h7FFF_FFFF, 32'hFFFF_0000, 3, 1'b0);
		push_item(hri_pkg::REQ_START, 0, $urandom, $urandom, $urandom, 1'b0);
		push_item(hri_pkg::REQ_EVAL, $urandom, 32'h0010_0000, 32'h0001_0000, 32'h0010_0000,
			1'b0);
		// Restart while running, once every result is back.
		push_item(hri_pkg::REQ_START, 32'h0003_0000, $urandom, $urandom, $urandom, 1'b1);
		push_item(hri_pkg::REQ_EVAL, $urandom, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			1'b0);
		settle();

		// Limit lowered while a run is active: the next update ends it.
		write_reg(hri_pkg::CFG_ITER_LIMIT, 1);
		push_item(hri_pkg::REQ_EVAL, $urandom, rand_mid() | 32'h0001_0000, 32'h0001_0000, 0,
			1'b0);
		run_random(150, 20);
		settle();

		write_reg(hri_pkg::CFG_ITER_LIMIT, 0);
		push_item(hri_pkg::REQ_START, $urandom, $urandom, $urandom, $urandom, 1'b0);
		push_item(hri_pkg::REQ_EVAL, $urandom, $urandom, $urandom, $urandom, 1'b0);
		run_random(60, 30);
		settle();

		write_reg(hri_pkg::CFG_TOLERANCE, 0);
		write_reg(hri_pkg::CFG_ITER_LIMIT, 32'h0000_FFFF);
		push_item(hri_pkg::REQ_START, $urandom, $urandom, $urandom, $urandom, 1'b0);
		push_item(hri_pkg::REQ_EVAL, $urandom, 1, 32'h0001_0000, 0, 1'b0);
		run_random(200, 25);
		settle();

		write_reg(hri_pkg::CFG_TOLERANCE, 32'h7FFF_FFFF);
		write_reg(hri_pkg::CFG_ITER_LIMIT, $urandom_range(2, 8));
		write_reg(CFG_UNUSED_A, $urandom);
		write_reg(CFG_UNUSED_B, $urandom);
		push_item(hri_pkg::REQ_START, $urandom, $urandom, $urandom, $urandom, 1'b0);
		push_item(hri_pkg::REQ_EVAL, $urandom, 32'h8000_0000, 0, 0, 1'b0);
		run_random(150, 30);
		settle();

		write_reg(hri_pkg::CFG_TOLERANCE, $urandom);
		write_reg(hri_pkg::CFG_ITER_LIMIT, $urandom_range(1, 20));
		run_random(200, 25);
		settle();

		write_reg(hri_pkg::CFG_TOLERANCE, $urandom_range(0, 2000));
		write_reg(hri_pkg::CFG_ITER_LIMIT, $urandom_range(3, 40));
		run_random(250, 15);
		settle();

		write_reg(hri_pkg::CFG_TOLERANCE, 32'(hri_pkg::TOL_RESET));
		write_reg(hri_pkg::CFG_ITER_LIMIT, 32'(hri_pkg::LIM_RESET));
		run_random(200, 30);
		settle();

		repeat (60) @(posedge clk);
		if (err_cnt == 0 && probe_exp_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
